// ===== sv/vtgd_pkg.sv =====
package vtgd_pkg;

	// command word layout
	localparam int unsigned COMMAND_BITS = 3;
	localparam int unsigned WORD_BITS    = 32;
	localparam int unsigned COUNT_BITS   = WORD_BITS - COMMAND_BITS;
	localparam int unsigned EXTENT_BITS  = 20;

	localparam logic [EXTENT_BITS-1:0] EXTENT_RESET = EXTENT_BITS'(4096);

	// command ids
	localparam logic [COMMAND_BITS-1:0] CMD_MOVE  = COMMAND_BITS'(1);
	localparam logic [COMMAND_BITS-1:0] CMD_LINE  = COMMAND_BITS'(2);
	localparam logic [COMMAND_BITS-1:0] CMD_CLOSE = COMMAND_BITS'(7);

	// geometry kinds
	localparam logic [1:0] KIND_LINE  = 2'd0;
	localparam logic [1:0] KIND_POLY  = 2'd1;
	localparam logic [1:0] KIND_POINT = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	typedef enum logic [1:0] {
		EV_MOVE    = 2'd0,
		EV_LINE    = 2'd1,
		EV_CLOSE   = 2'd2,
		EV_UNKNOWN = 2'd3
	} ev_kind_t;

	// one decoded result word
	typedef struct packed {
		logic                 valid;
		ev_kind_t             kind;
		logic [WORD_BITS-1:0] x;
		logic [WORD_BITS-1:0] y;
	} vtgd_res_t;

	// zigzag parameter to two's complement delta
	function automatic logic [WORD_BITS-1:0] unzigzag(input logic [WORD_BITS-1:0] w);
		return (w >> 1) ^ {WORD_BITS{w[0]}};
	endfunction

	// strictly inside 0..extent, signed
	function automatic logic inside_extent(input logic [WORD_BITS-1:0] v,
			input logic [EXTENT_BITS-1:0] ext);
		return !v[WORD_BITS-1] && (v != '0) &&
			(v < {{(WORD_BITS-EXTENT_BITS){1'b0}}, ext});
	endfunction

endpackage

// ===== sv/vtgd_parser.sv =====
module vtgd_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic [vtgd_pkg::WORD_BITS-1:0]  word,
	input  logic                            feat_start,
	input  logic [1:0]                      kind,
	input  logic [vtgd_pkg::EXTENT_BITS-1:0] extent,
	output vtgd_pkg::vtgd_res_t             res
);
	import vtgd_pkg::*;

	logic [COMMAND_BITS-1:0] cmd_q, cmd_e, cmd_n;
	logic [COUNT_BITS-1:0]   rep_q, rep_e, rep_n;
	logic                    await_q, await_e, await_n;
	logic                    ring_q, ring_e, ring_n;
	logic [WORD_BITS-1:0]    held_q, held_e, held_n;
	logic [WORD_BITS-1:0]    ax_q, ax_e, ax_n, ay_q, ay_e, ay_n;
	logic [WORD_BITS-1:0]    fx_q, fx_e, fx_n, fy_q, fy_e, fy_n;
	logic [WORD_BITS-1:0]    nx, ny;
	logic [COMMAND_BITS-1:0] id;
	logic [COUNT_BITS-1:0]   count;

	// feature start clears the parser before the word is decoded
	always_comb begin
		cmd_e   = feat_start ? '0 : cmd_q;
		rep_e   = feat_start ? '0 : rep_q;
		await_e = feat_start ? 1'b0 : await_q;
		ring_e  = feat_start ? 1'b0 : ring_q;
		held_e  = feat_start ? '0 : held_q;
		ax_e    = feat_start ? '0 : ax_q;
		ay_e    = feat_start ? '0 : ay_q;
		fx_e    = feat_start ? '0 : fx_q;
		fy_e    = feat_start ? '0 : fy_q;
	end

	assign id    = word[COMMAND_BITS-1:0];
	assign count = word[WORD_BITS-1:COMMAND_BITS];
	assign nx    = ax_e + held_e;
	assign ny    = ay_e + unzigzag(word);

	// decode and next state
	always_comb begin
		cmd_n   = cmd_e;
		rep_n   = rep_e;
		await_n = await_e;
		ring_n  = ring_e;
		held_n  = held_e;
		ax_n    = ax_e;
		ay_n    = ay_e;
		fx_n    = fx_e;
		fy_n    = fy_e;
		res     = '{valid: 1'b0, kind: EV_MOVE, x: '0, y: '0};
		if (rep_e == '0) begin
			// command word
			cmd_n   = id;
			await_n = 1'b0;
			if (count != '0) begin
				priority if (id == CMD_MOVE || id == CMD_LINE) begin
					rep_n = count;
				end else if (id == CMD_CLOSE) begin
					ring_n = 1'b0;
					if (ring_e && (kind == KIND_LINE || kind == KIND_POLY))
						res = '{valid: 1'b1, kind: EV_CLOSE, x: fx_e, y: fy_e};
				end else begin
					if (kind != KIND_NONE)
						res = '{valid: 1'b1, kind: EV_UNKNOWN, x: '0, y: '0};
				end
			end
		end else if (!await_e) begin
			// dx word, held
			held_n  = unzigzag(word);
			await_n = 1'b1;
		end else begin
			// dy word completes the vertex
			await_n = 1'b0;
			ax_n    = nx;
			ay_n    = ny;
			rep_n   = rep_e - COUNT_BITS'(1);
			ring_n  = 1'b1;
			if (cmd_e == CMD_MOVE) begin
				fx_n = nx;
				fy_n = ny;
			end
			if (kind != KIND_NONE &&
				(kind != KIND_POINT ||
				 (inside_extent(nx, extent) && inside_extent(ny, extent))))
				res = '{valid: 1'b1, kind: (cmd_e == CMD_MOVE) ? EV_MOVE : EV_LINE,
					x: nx, y: ny};
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= '0;
			rep_q   <= '0;
			await_q <= 1'b0;
			ring_q  <= 1'b0;
			held_q  <= '0;
			ax_q    <= '0;
			ay_q    <= '0;
			fx_q    <= '0;
			fy_q    <= '0;
		end else if (step) begin
			cmd_q   <= cmd_n;
			rep_q   <= rep_n;
			await_q <= await_n;
			ring_q  <= ring_n;
			held_q  <= held_n;
			ax_q    <= ax_n;
			ay_q    <= ay_n;
			fx_q    <= fx_n;
			fy_q    <= fy_n;
		end
	end

`ifndef NO_ASSERTIONS
	// a pending repeat only ever belongs to move-to or line-to
	a_rep_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q != '0 |-> (cmd_q == CMD_MOVE || cmd_q == CMD_LINE))
		else $error("repeat pending on a non-vertex command");

	// a held dx implies a pending repeat
	a_await_rep: assert property (@(posedge clk) disable iff (!arst_n)
		await_q |-> rep_q != '0)
		else $error("dx held without pending repeat");

	// a close vertex empties the ring
	a_close_ring: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid && res.kind == EV_CLOSE |=> !ring_q)
		else $error("ring still marked after close");
`endif

endmodule

// ===== sv/vector_tile_geometry_decoder.sv =====
// channel   handshake               word
// in        in_valid / in_ready     geom_word, feature_start, geom_kind
// out       out_valid / out_ready   event_kind, coord_x, coord_y
// cfg       cfg_valid / cfg_ready   layer_extent
//
// One word per cycle sustained while the result register is not stalled;
// a result is decoded from the input register into the result register.
// The parser state loop (accumulators, repeat count) closes through the
// parser registers. Reset clears the parser and sets the extent register
// to 4096; cfg_ready is always high. A stalled result register holds the
// input register, and in_ready drops only when both are full.
module vector_tile_geometry_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [vtgd_pkg::WORD_BITS-1:0]   geom_word,
	input  logic                             feature_start,
	input  logic [1:0]                       geom_kind,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       event_kind,
	output logic signed [vtgd_pkg::WORD_BITS-1:0] coord_x,
	output logic signed [vtgd_pkg::WORD_BITS-1:0] coord_y,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [vtgd_pkg::EXTENT_BITS-1:0] layer_extent
);
	import vtgd_pkg::*;

	logic                   v_s1, fs_s1;
	logic [WORD_BITS-1:0]   word_s1;
	logic [1:0]             kind_s1;
	logic                   ov_s2;
	ev_kind_t               ev_s2;
	logic [WORD_BITS-1:0]   x_s2, y_s2;
	logic [EXTENT_BITS-1:0] extent_q;
	logic                   adv;
	vtgd_res_t              res;

	assign adv       = v_s1 && (!ov_s2 || out_ready);
	assign in_ready  = !v_s1 || adv;
	assign cfg_ready = 1'b1;

	// extent register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extent_q <= EXTENT_RESET;
		end else if (cfg_valid) begin
			extent_q <= layer_extent;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= geom_word;
			fs_s1   <= feature_start;
			kind_s1 <= geom_kind;
		end
	end

	vtgd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.word       (word_s1),
		.feat_start (fs_s1),
		.kind       (kind_s1),
		.extent     (extent_q),
		.res        (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_s2 <= 1'b0;
		end else if (adv) begin
			ov_s2 <= res.valid;
		end else if (out_ready) begin
			ov_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ev_s2 <= res.kind;
			x_s2  <= res.x;
			y_s2  <= res.y;
		end
	end

	assign out_valid  = ov_s2;
	assign event_kind = ev_s2;
	assign coord_x    = x_s2;
	assign coord_y    = y_s2;

`ifndef NO_ASSERTIONS
	// a blocked input word stays put until the result side frees up
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(word_s1))
		else $error("input register lost a stalled word");

	// back-pressure only with a full input register
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && ov_s2 && !out_ready)
		else $error("in_ready low without a full pipeline");

	// unknown command results carry a zero vertex
	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_UNKNOWN |-> coord_x == '0 && coord_y == '0)
		else $error("unknown command with nonzero vertex");
`endif

endmodule
